FILE: src/ghbc_pkg.sv
package ghbc_pkg;

    localparam int NUM_BUTTONS_DEF = 16;
    localparam int VALUE_WIDTH_DEF = 12;

    localparam int ACT_W    = 2;
    localparam int HAT_W    = 4;
    localparam int BTN_W    = 4;
    localparam int TIME_W   = 32;
    localparam int CH_W     = 12;
    localparam int MODE_W   = 2;
    localparam int SLOW_W   = 10;
    localparam int DIV_W    = 16;
    localparam int DIV_BITS = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FAILSAFE = 3'd5;

    localparam int CENTER_RESET   = 1500;
    localparam int MIN_RESET      = 1000;
    localparam int MAX_RESET      = 2000;
    localparam int SLOW_RESET     = 5;
    localparam int DIVIDER_RESET  = 100;
    localparam int FAILSAFE_RESET = 1000;

    localparam logic [ACT_W-1:0] ACT_TICK    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_HAT     = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PRESS   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd3;

    localparam logic [HAT_W-1:0] HAT_CENTER     = 4'd0;
    localparam logic [HAT_W-1:0] HAT_UP         = 4'd1;
    localparam logic [HAT_W-1:0] HAT_UP_RIGHT   = 4'd2;
    localparam logic [HAT_W-1:0] HAT_RIGHT      = 4'd3;
    localparam logic [HAT_W-1:0] HAT_DOWN_RIGHT = 4'd4;
    localparam logic [HAT_W-1:0] HAT_DOWN       = 4'd5;
    localparam logic [HAT_W-1:0] HAT_DOWN_LEFT  = 4'd6;
    localparam logic [HAT_W-1:0] HAT_LEFT       = 4'd7;
    localparam logic [HAT_W-1:0] HAT_UP_LEFT    = 4'd8;

    localparam logic [MODE_W-1:0] MODE_RAMP   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SLOW   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MINMAX = 2'd2;

    localparam logic [BTN_W-1:0] BTN_RECENTER    = 4'd1;
    localparam logic [BTN_W-1:0] BTN_MODE_MINMAX = 4'd3;
    localparam logic [BTN_W-1:0] BTN_MODE_SLOW   = 4'd4;
    localparam logic [BTN_W-1:0] BTN_MODE_RAMP   = 4'd5;
    localparam logic [BTN_W-1:0] BTN_AUTOCENTER  = 4'd6;
    localparam logic [BTN_W-1:0] BTN_FLIGHT_LO   = 4'd7;
    localparam logic [BTN_W-1:0] BTN_AUX_LO      = 4'd8;
    localparam logic [BTN_W-1:0] BTN_FLIGHT_MID  = 4'd9;
    localparam logic [BTN_W-1:0] BTN_AUX_MID     = 4'd10;
    localparam logic [BTN_W-1:0] BTN_FLIGHT_HI   = 4'd11;
    localparam logic [BTN_W-1:0] BTN_AUX_HI      = 4'd12;

    localparam logic [CH_W-1:0] CH_LO  = 12'd1000;
    localparam logic [CH_W-1:0] CH_MID = 12'd1500;
    localparam logic [CH_W-1:0] CH_HI  = 12'd2000;

    localparam logic [TIME_W-1:0] HOLD_MS = 32'd100;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [HAT_W-1:0]  hat_dir;
        logic [BTN_W-1:0]  button_id;
        logic [TIME_W-1:0] now_ms;
    } in_t;

    typedef struct packed {
        logic [CH_W-1:0]   pitch_out;
        logic [CH_W-1:0]   yaw_out;
        logic [CH_W-1:0]   aux_channel;
        logic [CH_W-1:0]   flight_channel;
        logic [MODE_W-1:0] mode_out;
        logic              recenter_on;
    } out_t;

    typedef struct packed {
        logic load_in;
        logic div_start;
        logic div_yaw;
        logic cap_p;
        logic cap_y;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             div_done;
    } status_t;

endpackage

FILE: src/ghbc_div.sv
module ghbc_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [ghbc_pkg::TIME_W-1:0] dividend,
    input  logic [ghbc_pkg::DIV_W-1:0]  divisor,
    output logic                        done,
    output logic [ghbc_pkg::TIME_W-1:0] quotient
);

    localparam int TW    = ghbc_pkg::TIME_W;
    localparam int DW    = ghbc_pkg::DIV_W;
    localparam int STEPS = ghbc_pkg::TIME_W / ghbc_pkg::DIV_BITS;
    localparam int CNT_W = $clog2(STEPS);

    logic [TW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    always_comb begin
        logic [DW:0]   trial;
        logic [DW-1:0] r;
        logic [TW-1:0] q;
        r         = rem_reg;
        q         = quo_reg;
        trial     = '0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        for (int i = 0; i < ghbc_pkg::DIV_BITS; i++) begin
            trial = {r, q[TW-1]};
            q     = {q[TW-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg}) begin
                trial = trial - {1'b0, dvs_reg};
                q[0]  = 1'b1;
            end
            r = trial[DW-1:0];
        end
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = (divisor == '0) ? DW'(1) : divisor;
            cnt_next  = CNT_W'(STEPS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = q;
            rem_next = r;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: src/ghbc_dp.sv
module ghbc_dp #(
    parameter int NUM_BUTTONS = ghbc_pkg::NUM_BUTTONS_DEF,
    parameter int VALUE_WIDTH = ghbc_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [ghbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ghbc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  ghbc_pkg::in_t                   s_data,
    input  ghbc_pkg::cmd_t                  cmd,
    output ghbc_pkg::status_t               status,
    output ghbc_pkg::out_t                  m_data
);

    localparam int TW     = ghbc_pkg::TIME_W;
    localparam int CW     = ghbc_pkg::CH_W;
    localparam int VW     = VALUE_WIDTH;
    localparam int SUM_W  = ghbc_pkg::TIME_W + 1;
    localparam int PAD_W  = (VALUE_WIDTH > ghbc_pkg::CH_W) ? VALUE_WIDTH : ghbc_pkg::CH_W;
    localparam int DEPTH  = (NUM_BUTTONS < 16) ? NUM_BUTTONS : 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int VMAX_I = (1 << VALUE_WIDTH) - 1;
    localparam logic [SUM_W-1:0] VMAX_X = SUM_W'(VMAX_I);
    localparam logic [VW-1:0] CENTER_FIT =
        VW'((ghbc_pkg::CENTER_RESET > VMAX_I) ? VMAX_I : ghbc_pkg::CENTER_RESET);

    // configuration
    logic [CW-1:0]                   center_reg, min_reg, max_reg;
    logic [ghbc_pkg::SLOW_W-1:0]     slow_reg;
    logic [ghbc_pkg::DIV_W-1:0]      divider_reg;

    // block state
    logic [VW-1:0]                   pitch_reg, pitch_next;
    logic [VW-1:0]                   yaw_reg, yaw_next;
    logic [ghbc_pkg::MODE_W-1:0]     mode_reg, mode_next;
    logic                            ac_reg, ac_next;
    logic [ghbc_pkg::HAT_W-1:0]      hat_reg, hat_next;
    logic [TW-1:0]                   vert_reg, vert_next;
    logic [TW-1:0]                   horiz_reg, horiz_next;
    logic [CW-1:0]                   aux_reg, aux_next;
    logic [CW-1:0]                   flight_reg, flight_next;
    logic [DEPTH-1:0]                vld_reg, vld_next;

    // working registers
    ghbc_pkg::in_t                   in_reg;
    logic [TW-1:0]                   step_p_reg, step_y_reg;
    logic [TW-1:0]                   rd_reg;
    logic                            rd_vld_reg;
    ghbc_pkg::out_t                  out_reg, out_next;
    logic [TW-1:0]                   time_mem [DEPTH];

    logic [IDX_W-1:0]                idx;
    logic                            btn_ok;
    logic                            btn_wr;
    logic [TW-1:0]                   last_time;
    logic [TW-1:0]                   btn_elapsed;
    logic [ghbc_pkg::HAT_W-1:0]      hat_new;
    logic [TW-1:0]                   div_dividend;
    logic                            div_done;
    logic [TW-1:0]                   div_quotient;

    function automatic logic dir_up(input logic [ghbc_pkg::HAT_W-1:0] h);
        return h == ghbc_pkg::HAT_UP || h == ghbc_pkg::HAT_UP_RIGHT ||
               h == ghbc_pkg::HAT_UP_LEFT;
    endfunction

    function automatic logic dir_right(input logic [ghbc_pkg::HAT_W-1:0] h);
        return h == ghbc_pkg::HAT_UP_RIGHT || h == ghbc_pkg::HAT_RIGHT ||
               h == ghbc_pkg::HAT_DOWN_RIGHT;
    endfunction

    function automatic logic dir_down(input logic [ghbc_pkg::HAT_W-1:0] h);
        return h == ghbc_pkg::HAT_DOWN_RIGHT || h == ghbc_pkg::HAT_DOWN ||
               h == ghbc_pkg::HAT_DOWN_LEFT;
    endfunction

    function automatic logic dir_left(input logic [ghbc_pkg::HAT_W-1:0] h);
        return h == ghbc_pkg::HAT_DOWN_LEFT || h == ghbc_pkg::HAT_LEFT ||
               h == ghbc_pkg::HAT_UP_LEFT;
    endfunction

    function automatic logic [VW-1:0] fit(input logic [SUM_W-1:0] r);
        return (r > VMAX_X) ? VW'(VMAX_I) : r[VW-1:0];
    endfunction

    function automatic logic [CW-1:0] to_ch(input logic [VW-1:0] v);
        logic [PAD_W-1:0] t;
        t = PAD_W'(v);
        return t[CW-1:0];
    endfunction

    function automatic logic [VW-1:0] move_axis(input logic [VW-1:0] v,
                                                input logic inc,
                                                input logic dec,
                                                input logic [TW-1:0] ramp_step);
        logic [SUM_W-1:0] vx, cx, mnx, mxx, stp, sum, res;
        vx  = SUM_W'(v);
        cx  = SUM_W'(center_reg);
        mnx = SUM_W'(min_reg);
        mxx = SUM_W'(max_reg);
        stp = (mode_reg == ghbc_pkg::MODE_SLOW) ? SUM_W'(slow_reg) : SUM_W'(ramp_step);
        sum = vx + stp;
        res = vx;
        case (mode_reg)
            ghbc_pkg::MODE_RAMP, ghbc_pkg::MODE_SLOW: begin
                if (inc) begin
                    res = (sum > mxx) ? mxx : sum;
                end else if (dec) begin
                    res = (vx < stp + mnx) ? mnx : vx - stp;
                end else if (ac_reg) begin
                    if (mode_reg == ghbc_pkg::MODE_RAMP) begin
                        if (vx > cx) begin
                            res = vx - ((vx - cx) >> 2);
                        end else if (vx < cx) begin
                            res = vx + ((cx - vx) >> 2);
                        end
                    end else begin
                        // above center a step that would cross center is undone; below center the full step is taken
                        if (vx > cx) begin
                            res = (vx < cx + stp) ? vx : vx - stp;
                        end else if (vx < cx) begin
                            res = sum;
                        end
                    end
                end
            end
            ghbc_pkg::MODE_MINMAX: begin
                if (inc) begin
                    res = mxx;
                end else if (dec) begin
                    res = mnx;
                end else if (ac_reg) begin
                    res = cx;
                end
            end
            default: begin
                res = vx;
            end
        endcase
        return fit(res);
    endfunction

    ghbc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (divider_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign div_dividend = in_reg.now_ms - (cmd.div_yaw ? horiz_reg : vert_reg);

    assign idx         = in_reg.button_id[IDX_W-1:0];
    assign btn_ok      = 32'(in_reg.button_id) < NUM_BUTTONS;
    assign btn_wr      = cmd.commit && btn_ok &&
                         (in_reg.action == ghbc_pkg::ACT_PRESS ||
                          in_reg.action == ghbc_pkg::ACT_RELEASE);
    assign last_time   = rd_vld_reg ? rd_reg : '0;
    assign btn_elapsed = in_reg.now_ms - last_time;
    assign hat_new     = (in_reg.hat_dir > ghbc_pkg::HAT_UP_LEFT) ? ghbc_pkg::HAT_CENTER
                                                                  : in_reg.hat_dir;

    always_comb begin
        pitch_next  = pitch_reg;
        yaw_next    = yaw_reg;
        mode_next   = mode_reg;
        ac_next     = ac_reg;
        hat_next    = hat_reg;
        vert_next   = vert_reg;
        horiz_next  = horiz_reg;
        aux_next    = aux_reg;
        flight_next = flight_reg;
        vld_next    = vld_reg;
        if (btn_wr) begin
            vld_next[idx] = 1'b1;
        end
        if (cmd.commit) begin
            case (in_reg.action)
                ghbc_pkg::ACT_TICK: begin
                    pitch_next = move_axis(pitch_reg, dir_up(hat_reg), dir_down(hat_reg),
                                           step_p_reg);
                    yaw_next   = move_axis(yaw_reg, dir_right(hat_reg), dir_left(hat_reg),
                                           step_y_reg);
                end
                ghbc_pkg::ACT_HAT: begin
                    if (dir_up(hat_new) || dir_down(hat_new)) begin
                        vert_next = in_reg.now_ms;
                    end
                    if (dir_left(hat_new) || dir_right(hat_new)) begin
                        horiz_next = in_reg.now_ms;
                    end
                    if (hat_new == ghbc_pkg::HAT_CENTER) begin
                        vert_next  = '0;
                        horiz_next = '0;
                    end
                    hat_next = hat_new;
                end
                ghbc_pkg::ACT_PRESS, ghbc_pkg::ACT_RELEASE: begin
                    if (btn_ok && in_reg.action == ghbc_pkg::ACT_RELEASE &&
                        btn_elapsed > ghbc_pkg::HOLD_MS) begin
                        case (in_reg.button_id)
                            ghbc_pkg::BTN_AUX_LO:      aux_next    = ghbc_pkg::CH_LO;
                            ghbc_pkg::BTN_AUX_MID:     aux_next    = ghbc_pkg::CH_MID;
                            ghbc_pkg::BTN_AUX_HI:      aux_next    = ghbc_pkg::CH_HI;
                            ghbc_pkg::BTN_FLIGHT_LO:   flight_next = ghbc_pkg::CH_LO;
                            ghbc_pkg::BTN_FLIGHT_MID:  flight_next = ghbc_pkg::CH_MID;
                            ghbc_pkg::BTN_FLIGHT_HI:   flight_next = ghbc_pkg::CH_HI;
                            ghbc_pkg::BTN_RECENTER: begin
                                pitch_next = fit(SUM_W'(center_reg));
                                yaw_next   = fit(SUM_W'(center_reg));
                            end
                            ghbc_pkg::BTN_AUTOCENTER:  ac_next   = ~ac_reg;
                            ghbc_pkg::BTN_MODE_RAMP:   mode_next = ghbc_pkg::MODE_RAMP;
                            ghbc_pkg::BTN_MODE_SLOW:   mode_next = ghbc_pkg::MODE_SLOW;
                            ghbc_pkg::BTN_MODE_MINMAX: mode_next = ghbc_pkg::MODE_MINMAX;
                            default: begin
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end
        out_next                = out_reg;
        out_next.pitch_out      = to_ch(pitch_next);
        out_next.yaw_out        = to_ch(yaw_next);
        out_next.aux_channel    = aux_next;
        out_next.flight_channel = flight_next;
        out_next.mode_out       = mode_next;
        out_next.recenter_on    = ac_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg  <= CW'(ghbc_pkg::CENTER_RESET);
            min_reg     <= CW'(ghbc_pkg::MIN_RESET);
            max_reg     <= CW'(ghbc_pkg::MAX_RESET);
            slow_reg    <= ghbc_pkg::SLOW_W'(ghbc_pkg::SLOW_RESET);
            divider_reg <= ghbc_pkg::DIV_W'(ghbc_pkg::DIVIDER_RESET);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ghbc_pkg::CFG_CENTER:  center_reg  <= cfg_wr_data[CW-1:0];
                ghbc_pkg::CFG_MIN:     min_reg     <= cfg_wr_data[CW-1:0];
                ghbc_pkg::CFG_MAX:     max_reg     <= cfg_wr_data[CW-1:0];
                ghbc_pkg::CFG_SLOW:    slow_reg    <= cfg_wr_data[ghbc_pkg::SLOW_W-1:0];
                ghbc_pkg::CFG_DIVIDER: divider_reg <= cfg_wr_data[ghbc_pkg::DIV_W-1:0];
                // fail-safe writes are ignored; the channels reset to FAILSAFE_RESET
                ghbc_pkg::CFG_FAILSAFE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_reg  <= CENTER_FIT;
            yaw_reg    <= CENTER_FIT;
            mode_reg   <= ghbc_pkg::MODE_RAMP;
            ac_reg     <= 1'b0;
            hat_reg    <= ghbc_pkg::HAT_CENTER;
            vert_reg   <= '0;
            horiz_reg  <= '0;
            aux_reg    <= CW'(ghbc_pkg::FAILSAFE_RESET);
            flight_reg <= CW'(ghbc_pkg::FAILSAFE_RESET);
            vld_reg    <= '0;
        end else begin
            pitch_reg  <= pitch_next;
            yaw_reg    <= yaw_next;
            mode_reg   <= mode_next;
            ac_reg     <= ac_next;
            hat_reg    <= hat_next;
            vert_reg   <= vert_next;
            horiz_reg  <= horiz_next;
            aux_reg    <= aux_next;
            flight_reg <= flight_next;
            vld_reg    <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
        if (cmd.cap_p) begin
            step_p_reg <= div_quotient;
        end
        if (cmd.cap_y) begin
            step_y_reg <= div_quotient;
        end
        if (cmd.commit) begin
            out_reg <= out_next;
        end
    end

    // button time store
    always_ff @(posedge aclk) begin
        if (btn_wr) begin
            time_mem[idx] <= in_reg.now_ms;
        end
        rd_reg     <= time_mem[idx];
        rd_vld_reg <= vld_reg[idx];
    end

    assign status.action   = in_reg.action;
    assign status.div_done = div_done;
    assign m_data          = out_reg;

endmodule

FILE: src/ghbc_ctrl.sv
module ghbc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  ghbc_pkg::status_t status,
    output ghbc_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_DIV_P  = 3'd2;
    localparam logic [2:0] ST_DIV_Y  = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (status.action == ghbc_pkg::ACT_TICK) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_P;
                end else begin
                    state_next = ST_COMMIT;
                end
            end
            ST_DIV_P: begin
                if (status.div_done) begin
                    cmd.cap_p     = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_yaw   = 1'b1;
                    state_next    = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                if (status.div_done) begin
                    cmd.cap_y  = 1'b1;
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

FILE: src/gimbal_hat_and_button_controller.sv
// Camera gimbal control from joystick hat and button transactions. Each input
// transaction yields exactly one result transaction carrying pitch, yaw, both
// mode channels, camera mode and auto-center state after that event. For a
// tick the ramp step of each axis comes from one shared iterative 32/16
// divider that retires two quotient bits per cycle (pitch then yaw), and the
// divide runs on every tick whatever the mode; hat and button transactions
// skip it. Input is accepted again in the cycle after a result is loaded,
// also while that result waits in the output register; a result still
// waiting when the next one is ready holds it back until the first is taken.
// Configuration writes are taken in any cycle but must only be issued while
// the block is idle.
module gimbal_hat_and_button_controller #(
    parameter int NUM_BUTTONS = ghbc_pkg::NUM_BUTTONS_DEF,
    parameter int VALUE_WIDTH = ghbc_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [ghbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ghbc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  ghbc_pkg::in_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output ghbc_pkg::out_t                  m_data
);

    ghbc_pkg::cmd_t    cmd;
    ghbc_pkg::status_t status;

    ghbc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ghbc_dp #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .cmd         (cmd),
        .status      (status),
        .m_data      (m_data)
    );

endmodule

FILE: src/ghbc_checker.sv
module ghbc_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input ghbc_pkg::out_t m_data
);

    logic [1:0] pend_reg, pend_next;

    always_comb begin
        pend_next = pend_reg;
        if (s_valid && s_ready && !(m_valid && m_ready)) begin
            pend_next = pend_reg + 2'd1;
        end else if (!(s_valid && s_ready) && m_valid && m_ready) begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_pend_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != 2'd3)
        else $error("more than two transactions in flight");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != 2'd0)
        else $error("result without an accepted transaction");

endmodule

bind gimbal_hat_and_button_controller ghbc_checker u_ghbc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ghbc_pkg::*;

    localparam int LATENCY_CYCLES  = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PRINT_LIMIT     = 40;
    localparam int CENTER_PULL_DIV = 4;
    localparam longint CODE_MAX    = (longint'(1) << VALUE_WIDTH_DEF) - 1;

    localparam logic [HAT_W-1:0] HAT_BAD_LO = HAT_UP_LEFT + 1'b1;
    localparam logic [HAT_W-1:0] HAT_BAD_HI = '1;
    localparam logic [BTN_W-1:0] BTN_IDLE_LO = '0;
    localparam logic [BTN_W-1:0] BTN_IDLE_HI = '1;

    typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} sink_pat_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    in_t                   s_data      = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    out_t                  m_data;

    gimbal_hat_and_button_controller DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // shadow copy of registers and gimbal state
    logic [CH_W-1:0]   reg_center, reg_min, reg_max, reg_failsafe;
    logic [SLOW_W-1:0] reg_slow;
    logic [DIV_W-1:0]  reg_div;
    logic [CH_W-1:0]   cam_pitch, cam_yaw, aux_level, flight_level;
    logic [MODE_W-1:0] gim_mode;
    logic              centering_on;
    logic [HAT_W-1:0]  hat_pos;
    logic [TIME_W-1:0] vert_since, horiz_since;
    logic [TIME_W-1:0] edge_ms [NUM_BUTTONS_DEF];

    out_t readings_due [$];
    out_t due;

    int        items_sent       = 0;
    int        results_seen     = 0;
    int        mismatches       = 0;
    int        settings_applied = 0;
    int        burst_left       = 0;
    bit        gapless          = 1'b0;
    logic [TIME_W-1:0] clock_ms = '0;

    int        hold_requests = 0;
    int        holds_served  = 0;
    int        hold_left     = 0;
    int        sink_left     = 0;
    int        sink_phase    = 0;
    sink_pat_t sink_mode     = SINK_OPEN;

    function automatic logic [CH_W-1:0] clamp_code(longint v);
        if (v < 0) return '0;
        if (v > CODE_MAX) return CH_W'(CODE_MAX);
        return CH_W'(v);
    endfunction

    function automatic bit hat_up(logic [HAT_W-1:0] h);
        return h == HAT_UP || h == HAT_UP_RIGHT || h == HAT_UP_LEFT;
    endfunction

    function automatic bit hat_right(logic [HAT_W-1:0] h);
        return h == HAT_UP_RIGHT || h == HAT_RIGHT || h == HAT_DOWN_RIGHT;
    endfunction

    function automatic bit hat_down(logic [HAT_W-1:0] h);
        return h == HAT_DOWN_RIGHT || h == HAT_DOWN || h == HAT_DOWN_LEFT;
    endfunction

    function automatic bit hat_left(logic [HAT_W-1:0] h);
        return h == HAT_DOWN_LEFT || h == HAT_LEFT || h == HAT_UP_LEFT;
    endfunction

    function automatic void reset_model();
        reg_center   = CH_W'(CENTER_RESET);
        reg_min      = CH_W'(MIN_RESET);
        reg_max      = CH_W'(MAX_RESET);
        reg_slow     = SLOW_W'(SLOW_RESET);
        reg_div      = DIV_W'(DIVIDER_RESET);
        reg_failsafe = CH_W'(FAILSAFE_RESET);
        cam_pitch    = clamp_code(reg_center);
        cam_yaw      = clamp_code(reg_center);
        gim_mode     = MODE_RAMP;
        centering_on = 1'b0;
        hat_pos      = HAT_CENTER;
        vert_since   = '0;
        horiz_since  = '0;
        aux_level    = reg_failsafe;
        flight_level = reg_failsafe;
        foreach (edge_ms[i]) edge_ms[i] = '0;
    endfunction

    function automatic logic [CH_W-1:0] steer_axis(logic [CH_W-1:0] val, bit inc, bit dec,
                                                   logic [TIME_W-1:0] since,
                                                   logic [TIME_W-1:0] now);
        longint v, c, lo, hi, stp;
        logic [TIME_W-1:0] lapse, dv;
        v     = val;
        c     = reg_center;
        lo    = reg_min;
        hi    = reg_max;
        lapse = now - since;
        dv    = (reg_div == '0) ? TIME_W'(1) : TIME_W'(reg_div);
        stp   = (gim_mode == MODE_RAMP) ? lapse / dv : reg_slow;
        case (gim_mode)
            MODE_RAMP, MODE_SLOW: begin
                if (inc) begin
                    v += stp;
                    if (v > hi) v = hi;
                end
                if (dec) begin
                    v -= stp;
                    if (v < lo) v = lo;
                end
                v = clamp_code(v);
                if (centering_on && !inc && !dec) begin
                    if (gim_mode == MODE_RAMP) begin
                        if (v > c) v -= (v - c) / CENTER_PULL_DIV;
                        if (v < c) v += (c - v) / CENTER_PULL_DIV;
                    end else begin
                        if (v > c) v -= stp;
                        if (v < c) v += stp;
                    end
                end
            end
            MODE_MINMAX: begin
                if (inc) v = hi;
                if (dec) v = lo;
                if (centering_on && !inc && !dec) v = c;
            end
            default: ;
        endcase
        return clamp_code(v);
    endfunction

    function automatic out_t advance_gimbal(in_t ev);
        logic [HAT_W-1:0]  h;
        logic [TIME_W-1:0] lapse;
        out_t              res;
        case (ev.action)
            ACT_TICK: begin
                cam_pitch = steer_axis(cam_pitch, hat_up(hat_pos), hat_down(hat_pos),
                                       vert_since, ev.now_ms);
                cam_yaw   = steer_axis(cam_yaw, hat_right(hat_pos), hat_left(hat_pos),
                                       horiz_since, ev.now_ms);
            end
            ACT_HAT: begin
                h = (ev.hat_dir > HAT_UP_LEFT) ? HAT_CENTER : ev.hat_dir;
                if (hat_up(h) || hat_down(h)) vert_since = ev.now_ms;
                if (hat_left(h) || hat_right(h)) horiz_since = ev.now_ms;
                if (h == HAT_CENTER) begin
                    vert_since  = '0;
                    horiz_since = '0;
                end
                hat_pos = h;
            end
            default: begin
                if (int'(ev.button_id) < NUM_BUTTONS_DEF) begin
                    lapse = ev.now_ms - edge_ms[ev.button_id];
                    edge_ms[ev.button_id] = ev.now_ms;
                    if (ev.action == ACT_RELEASE && lapse > HOLD_MS) begin
                        case (ev.button_id)
                            BTN_AUX_LO:      aux_level    = CH_LO;
                            BTN_AUX_MID:     aux_level    = CH_MID;
                            BTN_AUX_HI:      aux_level    = CH_HI;
                            BTN_FLIGHT_LO:   flight_level = CH_LO;
                            BTN_FLIGHT_MID:  flight_level = CH_MID;
                            BTN_FLIGHT_HI:   flight_level = CH_HI;
                            BTN_RECENTER: begin
                                cam_pitch = clamp_code(reg_center);
                                cam_yaw   = clamp_code(reg_center);
                            end
                            BTN_AUTOCENTER:  centering_on = !centering_on;
                            BTN_MODE_RAMP:   gim_mode = MODE_RAMP;
                            BTN_MODE_SLOW:   gim_mode = MODE_SLOW;
                            BTN_MODE_MINMAX: gim_mode = MODE_MINMAX;
                            default: ;
                        endcase
                    end
                end
            end
        endcase
        res.pitch_out      = cam_pitch;
        res.yaw_out        = cam_yaw;
        res.aux_channel    = aux_level;
        res.flight_channel = flight_level;
        res.mode_out       = gim_mode;
        res.recenter_on    = centering_on;
        return res;
    endfunction

    // offers one transaction; back-to-back calls keep valid high through a burst
    task automatic push_event(logic [ACT_W-1:0] act, logic [HAT_W-1:0] hat,
                              logic [BTN_W-1:0] btn, logic [TIME_W-1:0] now);
        int  gap;
        in_t ev;
        ev.action    = act;
        ev.hat_dir   = hat;
        ev.button_id = btn;
        ev.now_ms    = now;
        if (!gapless && burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 :
                  $urandom_range(1, ($urandom_range(0, 3) == 0) ? 45 : 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        if (burst_left > 0) burst_left--;
        s_valid <= 1'b1;
        s_data  <= ev;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        readings_due.push_back(advance_gimbal(ev));
        items_sent++;
    endtask

    task automatic settle_block();
        s_valid <= 1'b0;
        while (readings_due.size() != 0) @(posedge aclk);
        repeat (LATENCY_CYCLES) @(posedge aclk);
    endtask

    task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_CENTER:   reg_center   = data[CH_W-1:0];
            CFG_MIN:      reg_min      = data[CH_W-1:0];
            CFG_MAX:      reg_max      = data[CH_W-1:0];
            CFG_SLOW:     reg_slow     = data[SLOW_W-1:0];
            CFG_DIVIDER:  reg_div      = data[DIV_W-1:0];
            CFG_FAILSAFE: reg_failsafe = data[CH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [CFG_DATA_W-1:0] center, logic [CFG_DATA_W-1:0] lo,
                                  logic [CFG_DATA_W-1:0] hi, logic [CFG_DATA_W-1:0] slow,
                                  logic [CFG_DATA_W-1:0] div, logic [CFG_DATA_W-1:0] fs);
        write_setting(CFG_CENTER, center);
        write_setting(CFG_MIN, lo);
        write_setting(CFG_MAX, hi);
        write_setting(CFG_SLOW, slow);
        write_setting(CFG_DIVIDER, div);
        write_setting(CFG_FAILSAFE, fs);
        settings_applied++;
    endtask

    // mostly plausible joystick use: ticks, hat moves, press/release pairs, some noise
    task automatic run_traffic(int n);
        int               sent, pick, hold;
        logic [BTN_W-1:0] btn;
        logic [HAT_W-1:0] dir;
        sent = 0;
        while (sent < n) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) == 0)
                clock_ms = $urandom;
            else
                clock_ms += ($urandom_range(0, 9) == 0) ? $urandom_range(150, 4000)
                                                        : $urandom_range(0, 150);
            if (pick < 40) begin
                push_event(ACT_TICK, HAT_W'($urandom), BTN_W'($urandom), clock_ms);
                sent++;
            end else if (pick < 60) begin
                dir = ($urandom_range(0, 9) == 0) ? HAT_W'($urandom_range(9, 15))
                                                  : HAT_W'($urandom_range(0, 8));
                push_event(ACT_HAT, dir, BTN_W'($urandom), clock_ms);
                sent++;
            end else if (pick < 93) begin
                btn = BTN_W'($urandom);
                if ($urandom_range(0, 9) != 0) begin
                    push_event(ACT_PRESS, HAT_W'($urandom), btn, clock_ms);
                    sent++;
                end
                case ($urandom_range(0, 3))
                    0:       hold = $urandom_range(0, 99);
                    1:       hold = $urandom_range(100, 101);
                    default: hold = $urandom_range(102, 800);
                endcase
                clock_ms += hold;
                push_event(ACT_RELEASE, HAT_W'($urandom), btn, clock_ms);
                sent++;
            end else begin
                push_event(ACT_W'($urandom), HAT_W'($urandom), BTN_W'($urandom), $urandom);
                sent++;
            end
        end
    endtask

    task automatic test_directed_events();
        logic [BTN_W-1:0] chan_btns [6];
        chan_btns = '{BTN_FLIGHT_LO, BTN_AUX_LO, BTN_FLIGHT_MID, BTN_AUX_MID,
                      BTN_FLIGHT_HI, BTN_AUX_HI};
        push_event(ACT_TICK, HAT_W'($urandom), BTN_W'($urandom), 32'd0);
        push_event(ACT_HAT, HAT_UP, BTN_W'($urandom), 32'd1000);
        push_event(ACT_TICK, HAT_W'($urandom), BTN_W'($urandom), 32'd1550);
        push_event(ACT_TICK, HAT_W'($urandom), BTN_W'($urandom), 32'hFFFF_FFFF);
        push_event(ACT_HAT, HAT_BAD_LO, BTN_W'($urandom), 32'd5);
        push_event(ACT_HAT, HAT_RIGHT, BTN_W'($urandom), 32'hFFFF_FF00);
        push_event(ACT_TICK, HAT_W'($urandom), BTN_W'($urandom), 32'h0000_0100);
        // hold of exactly the threshold must not act, one more ms must
        push_event(ACT_PRESS, HAT_W'($urandom), BTN_AUTOCENTER, 32'd2000);
        push_event(ACT_RELEASE, HAT_W'($urandom), BTN_AUTOCENTER, 32'd2000 + HOLD_MS);
        push_event(ACT_RELEASE, HAT_W'($urandom), BTN_AUTOCENTER, 32'd2101 + HOLD_MS);
        push_event(ACT_HAT, HAT_CENTER, BTN_W'($urandom), 32'd2300);
        push_event(ACT_TICK, HAT_W'($urandom), BTN_W'($urandom), 32'd2400);
        push_event(ACT_RELEASE, HAT_W'($urandom), BTN_MODE_SLOW, 32'd3000);
        push_event(ACT_TICK, HAT_W'($urandom), BTN_W'($urandom), 32'd3100);
        push_event(ACT_RELEASE, HAT_W'($urandom), BTN_MODE_MINMAX, 32'd3200);
        push_event(ACT_HAT, HAT_DOWN_LEFT, BTN_W'($urandom), 32'd3300);
        push_event(ACT_TICK, HAT_W'($urandom), BTN_W'($urandom), 32'd3400);
        push_event(ACT_HAT, HAT_UP_RIGHT, BTN_W'($urandom), 32'd3450);
        push_event(ACT_TICK, HAT_W'($urandom), BTN_W'($urandom), 32'd3460);
        push_event(ACT_RELEASE, HAT_W'($urandom), BTN_RECENTER, 32'd3500);
        foreach (chan_btns[i])
            push_event(ACT_RELEASE, HAT_W'($urandom), chan_btns[i], 32'd4000 + 200 * i);
        push_event(ACT_RELEASE, HAT_W'($urandom), BTN_IDLE_LO, 32'd5500);
        push_event(ACT_RELEASE, HAT_W'($urandom), BTN_IDLE_HI, 32'd5600);
        push_event(ACT_HAT, HAT_BAD_HI, BTN_W'($urandom), 32'd5700);
        push_event(ACT_RELEASE, HAT_W'($urandom), BTN_MODE_RAMP, 32'd6000);
        clock_ms = 32'd10000;
        settle_block();
    endtask

    task automatic test_default_settings();
        run_traffic(140);
        settle_block();
    endtask

    task automatic test_extreme_settings();
        // upper write bits beyond each register width must be dropped
        apply_settings(16'hF000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFF);
        run_traffic(90);
        settle_block();
        apply_settings(16'h0FFF, 16'h0FFF, 16'h0000, 16'hFC00, 16'hFFFF, 16'h0000);
        run_traffic(90);
        settle_block();
    endtask

    task automatic test_zero_divider();
        apply_settings(CFG_DATA_W'(CENTER_RESET), CFG_DATA_W'(MIN_RESET),
                       CFG_DATA_W'(MAX_RESET), CFG_DATA_W'(SLOW_RESET), 16'h0000,
                       CFG_DATA_W'(FAILSAFE_RESET));
        clock_ms += 1000;
        push_event(ACT_RELEASE, HAT_W'($urandom), BTN_MODE_RAMP, clock_ms);
        push_event(ACT_HAT, HAT_DOWN, BTN_W'($urandom), clock_ms + 10);
        push_event(ACT_TICK, HAT_W'($urandom), BTN_W'($urandom), clock_ms + 300);
        clock_ms += 300;
        run_traffic(80);
        settle_block();
    endtask

    task automatic test_backpressure();
        gapless = 1'b1;
        hold_requests <= hold_requests + 1;
        for (int i = 0; i < 14; i++) begin
            clock_ms += 37;
            push_event((i % 3 == 0) ? ACT_HAT : ACT_TICK, HAT_W'($urandom_range(0, 8)),
                       BTN_W'($urandom), clock_ms);
        end
        gapless = 1'b0;
        settle_block();
    endtask

    task automatic test_random_settings();
        int c, lo, hi;
        repeat (3) begin
            if ($urandom_range(0, 1) == 0) begin
                apply_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                               CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                               CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
            end else begin
                lo = $urandom_range(0, 1500);
                hi = $urandom_range(2000, 4095);
                c  = $urandom_range(lo, hi);
                apply_settings(CFG_DATA_W'(c), CFG_DATA_W'(lo), CFG_DATA_W'(hi),
                               CFG_DATA_W'($urandom_range(0, 64)),
                               CFG_DATA_W'($urandom_range(1, 500)),
                               CFG_DATA_W'($urandom_range(0, 4095)));
            end
            run_traffic(80);
            settle_block();
        end
    endtask

    // result sink: random stall patterns plus a requested long hold-off
    always @(posedge aclk) begin
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = HOLD_OFF_CYCLES;
        end
        sink_phase++;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (sink_left == 0) begin
                sink_mode = sink_pat_t'($urandom_range(0, 3));
                sink_left = $urandom_range(20, 300);
            end
            sink_left--;
            case (sink_mode)
                SINK_OPEN:   m_ready <= 1'b1;
                SINK_COIN:   m_ready <= 1'($urandom_range(0, 1));
                SINK_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:     m_ready <= (sink_phase % 7) < 3;
            endcase
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (readings_due.size() == 0) begin
                mismatches++;
                if (mismatches <= PRINT_LIMIT)
                    $display("%0t: result expected none actual %p", $time, m_data);
            end else begin
                due = readings_due.pop_front();
                check_field("pitch_out", due.pitch_out, m_data.pitch_out);
                check_field("yaw_out", due.yaw_out, m_data.yaw_out);
                check_field("aux_channel", due.aux_channel, m_data.aux_channel);
                check_field("flight_channel", due.flight_channel, m_data.flight_channel);
                check_field("mode_out", due.mode_out, m_data.mode_out);
                check_field("recenter_on", due.recenter_on, m_data.recenter_on);
                results_seen++;
            end
        end
    end

    initial begin
        reset_model();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_events();
        test_default_settings();
        test_extreme_settings();
        test_zero_divider();
        test_backpressure();
        test_random_settings();
        settle_block();
        $display("Checked %0d results of %0d transactions under %0d register settings,",
                 results_seen, items_sent, settings_applied + 1);
        $display("all hat positions, buttons and camera modes, with a %0d-cycle output stall",
                 HOLD_OFF_CYCLES);
        if (mismatches == 0 && readings_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", readings_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
